FILE: hdl/cbsu_pkg.sv
// Shared types, codes and helpers for the CB-prefix bit and shift unit.
`default_nettype none
package cbsu_pkg;

    localparam int SLOT_W    = 3;
    localparam int NUM_SLOTS = 7;

    localparam logic [SLOT_W-1:0] SLOT_H = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_L = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_A = 3'd6;

    localparam logic [2:0] SEL_B     = 3'd0;
    localparam logic [2:0] SEL_C     = 3'd1;
    localparam logic [2:0] SEL_D     = 3'd2;
    localparam logic [2:0] SEL_E     = 3'd3;
    localparam logic [2:0] SEL_H     = 3'd4;
    localparam logic [2:0] SEL_L     = 3'd5;
    localparam logic [2:0] SEL_MEM   = 3'd6;
    localparam logic [2:0] SEL_A     = 3'd7;
    localparam logic [2:0] IDX_FLAGS = 3'd6;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] GRP_ROT = 2'd0;
    localparam logic [1:0] GRP_BIT = 2'd1;
    localparam logic [1:0] GRP_RES = 2'd2;
    localparam logic [1:0] GRP_SET = 2'd3;

    localparam logic [2:0] ROT_RLC  = 3'd0;
    localparam logic [2:0] ROT_RRC  = 3'd1;
    localparam logic [2:0] ROT_RL   = 3'd2;
    localparam logic [2:0] ROT_RR   = 3'd3;
    localparam logic [2:0] ROT_SLA  = 3'd4;
    localparam logic [2:0] ROT_SRA  = 3'd5;
    localparam logic [2:0] ROT_SWAP = 3'd6;
    localparam logic [2:0] ROT_SRL  = 3'd7;

    localparam int FLG_Z = 3;
    localparam int FLG_N = 2;
    localparam int FLG_H = 1;
    localparam int FLG_C = 0;

    typedef struct packed {
        logic       cmd;
        logic [7:0] opcode;
        logic [7:0] mem_data;
        logic [2:0] reg_index;
        logic [7:0] reg_value;
    } item_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
    } rf_wr_t;

    typedef struct packed {
        logic [7:0] value;
        logic       mem_write;
        logic [3:0] flags;
    } exec_res_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] sel);
        return (sel == SEL_A) ? SLOT_A : sel;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cbsu_regfile.sv
// Register file memory with a registered read port and write forwarding.
`default_nettype none
module cbsu_regfile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [cbsu_pkg::SLOT_W-1:0]   rd_slot,
    input  wire cbsu_pkg::rf_wr_t              wr,
    output logic [7:0]                         rd_data
);

    logic [7:0]                       mem [cbsu_pkg::NUM_SLOTS];
    logic [7:0]                       rd_data_reg;
    logic                             rd_vld_reg;
    logic [cbsu_pkg::SLOT_W-1:0]      rd_slot_reg;
    logic [cbsu_pkg::NUM_SLOTS-1:0]   valid_reg;
    cbsu_pkg::rf_wr_t                 fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.slot] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_slot_reg <= '0;
            fwd_reg     <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.slot] <= 1'b1;
                fwd_reg            <= wr;
            end
            if (rd_en)
            begin
                rd_vld_reg  <= valid_reg[rd_slot];
                rd_slot_reg <= rd_slot;
            end
        end
    end

    always_comb
    begin
        if (fwd_reg.en && (fwd_reg.slot == rd_slot_reg))
        begin
            rd_data = fwd_reg.data;
        end
        else if (rd_vld_reg)
        begin
            rd_data = rd_data_reg;
        end
        else
        begin
            rd_data = 8'h00;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cbsu_exec.sv
// Combinational execute logic for CB opcodes and register or flag loads.
`default_nettype none
module cbsu_exec (
    input  wire cbsu_pkg::item_t     item,
    input  wire logic [7:0]          operand,
    input  wire logic [3:0]          flags,
    output cbsu_pkg::exec_res_t      res,
    output cbsu_pkg::rf_wr_t         wr
);

    logic [2:0] sel;
    logic [2:0] n;
    logic [1:0] grp;
    logic       is_mem;
    logic [7:0] v;
    logic [7:0] rot_r;
    logic       cout;
    logic       cin;
    logic [7:0] bit_mask;

    assign sel      = item.opcode[2:0];
    assign n        = item.opcode[5:3];
    assign grp      = item.opcode[7:6];
    assign is_mem   = (sel == cbsu_pkg::SEL_MEM);
    assign v        = is_mem ? item.mem_data : operand;
    assign cin      = flags[cbsu_pkg::FLG_C];
    assign bit_mask = 8'h01 << n;

    always_comb
    begin
        unique case (n)
            cbsu_pkg::ROT_RLC:
            begin
                cout  = v[7];
                rot_r = {v[6:0], v[7]};
            end
            cbsu_pkg::ROT_RRC:
            begin
                cout  = v[0];
                rot_r = {v[0], v[7:1]};
            end
            cbsu_pkg::ROT_RL:
            begin
                cout  = v[7];
                rot_r = {v[6:0], cin};
            end
            cbsu_pkg::ROT_RR:
            begin
                cout  = v[0];
                rot_r = {cin, v[7:1]};
            end
            cbsu_pkg::ROT_SLA:
            begin
                cout  = v[7];
                rot_r = {v[6:0], 1'b0};
            end
            cbsu_pkg::ROT_SRA:
            begin
                cout  = v[0];
                rot_r = {v[7], v[7:1]};
            end
            cbsu_pkg::ROT_SWAP:
            begin
                cout  = 1'b0;
                rot_r = {v[3:0], v[7:4]};
            end
            default:
            begin
                cout  = v[0];
                rot_r = {1'b0, v[7:1]};
            end
        endcase
    end

    always_comb
    begin
        res       = '0;
        wr        = '0;
        res.flags = flags;
        if (item.cmd == cbsu_pkg::CMD_LOAD)
        begin
            if (item.reg_index == cbsu_pkg::IDX_FLAGS)
            begin
                res.flags = item.reg_value[7:4];
                res.value = {item.reg_value[7:4], 4'h0};
            end
            else
            begin
                res.value = item.reg_value;
                wr.en     = 1'b1;
                wr.slot   = cbsu_pkg::slot_of(item.reg_index);
                wr.data   = item.reg_value;
            end
        end
        else
        begin
            unique case (grp)
                cbsu_pkg::GRP_ROT:
                begin
                    res.value                 = rot_r;
                    res.flags                 = '0;
                    res.flags[cbsu_pkg::FLG_Z] = (rot_r == 8'h00);
                    res.flags[cbsu_pkg::FLG_C] = cout;
                end
                cbsu_pkg::GRP_BIT:
                begin
                    res.value                 = v;
                    res.flags[cbsu_pkg::FLG_Z] = ~v[n];
                    res.flags[cbsu_pkg::FLG_N] = 1'b0;
                    res.flags[cbsu_pkg::FLG_H] = 1'b1;
                end
                cbsu_pkg::GRP_RES:
                begin
                    res.value = v & ~bit_mask;
                end
                default:
                begin
                    res.value = v | bit_mask;
                end
            endcase
            if (grp != cbsu_pkg::GRP_BIT)
            begin
                if (is_mem)
                begin
                    res.mem_write = 1'b1;
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.slot = cbsu_pkg::slot_of(sel);
                    wr.data = res.value;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cb_prefix_bit_shift_unit_top.sv
// Stage one registers a beat and its operand; the output register holds its result.
// Throughput: one beat per cycle while m_axis_tready is high, set by the registered
// register file read port, with the last write forwarded to the following read.
// The output register holds a result while the next beat is taken.
// Reset clears registers B to A, HL and the flags to zero and empties the pipeline.
`default_nettype none
module cb_prefix_bit_shift_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[7:0], mem_data[15:8], reg_index[18:16], reg_value[26:19], zero fill
    input  wire logic [31:0] s_axis_tdata,
    // cmd[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_value[7:0], mem_write[8], mem_address[24:9], flag_zero[25],
    // flag_negative[26], flag_half[27], flag_carry[28], zero fill
    output logic [31:0]      m_axis_tdata
);

    cbsu_pkg::item_t      in_item;
    cbsu_pkg::item_t      s1_item_reg;
    logic                 s1_valid_reg;
    logic                 s1_adv;
    logic                 accept;
    logic [7:0]           operand;
    logic [3:0]           flags_reg;
    logic [7:0]           h_reg;
    logic [7:0]           l_reg;
    logic [7:0]           h_next;
    logic [7:0]           l_next;
    cbsu_pkg::exec_res_t  ex_res;
    cbsu_pkg::rf_wr_t     ex_wr;
    cbsu_pkg::rf_wr_t     rf_wr;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;

    assign in_item.cmd       = s_axis_tuser;
    assign in_item.opcode    = s_axis_tdata[7:0];
    assign in_item.mem_data  = s_axis_tdata[15:8];
    assign in_item.reg_index = s_axis_tdata[18:16];
    assign in_item.reg_value = s_axis_tdata[26:19];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cbsu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_slot (cbsu_pkg::slot_of(in_item.opcode[2:0])),
        .wr      (rf_wr),
        .rd_data (operand)
    );

    cbsu_exec u_exec (
        .item    (s1_item_reg),
        .operand (operand),
        .flags   (flags_reg),
        .res     (ex_res),
        .wr      (ex_wr)
    );

    always_comb
    begin
        rf_wr    = ex_wr;
        rf_wr.en = ex_wr.en && s1_adv;
        h_next   = (ex_wr.en && (ex_wr.slot == cbsu_pkg::SLOT_H)) ? ex_wr.data : h_reg;
        l_next   = (ex_wr.en && (ex_wr.slot == cbsu_pkg::SLOT_L)) ? ex_wr.data : l_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_data_reg <= {3'b000,
                             ex_res.flags[cbsu_pkg::FLG_C],
                             ex_res.flags[cbsu_pkg::FLG_H],
                             ex_res.flags[cbsu_pkg::FLG_N],
                             ex_res.flags[cbsu_pkg::FLG_Z],
                             h_next, l_next,
                             ex_res.mem_write,
                             ex_res.value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            h_reg         <= '0;
            l_reg         <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= ex_res.flags;
                h_reg         <= h_next;
                l_reg         <= l_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire
